### hw/rtl/bmme_pkg.sv
// ----------------------------------------------------------------------------
// bmme_pkg
// Shared constants, types and helpers for the block min/max envelope.
// ----------------------------------------------------------------------------
package bmme_pkg;

    localparam int MAX_BLOCK = 512;

    localparam int SAMPLE_W = 24;
    localparam int PCM_W    = 16;
    localparam int SHIFT_W  = 2;
    localparam int LENREG_W = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int LEN_W = (CNT_W > LENREG_W) ? CNT_W : LENREG_W;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMATE_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH   = 1'd1;

    localparam logic [SHIFT_W-1:0] SHIFT_KEEP_ALL = 2'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_HALF     = 2'd1;

    localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7fff;
    localparam logic signed [PCM_W-1:0] PCM_MIN = 16'sh8000;

    localparam logic [LENREG_W-1:0] BLOCK_LENGTH_RESET = LENREG_W'(512);

    typedef struct packed {
        logic [SHIFT_W-1:0] phase_mask;
        logic [LEN_W-1:0]   eff_len;
    } cfg_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last;
    } item_t;

    function automatic logic signed [PCM_W-1:0] saturate(
        input logic signed [SAMPLE_W-1:0] s
    );
        logic signed [PCM_W-1:0] r;
        if (s < $signed({{(SAMPLE_W-PCM_W){PCM_MIN[PCM_W-1]}}, PCM_MIN}))
        begin
            r = PCM_MIN;
        end
        else if (s > $signed({{(SAMPLE_W-PCM_W){1'b0}}, PCM_MAX}))
        begin
            r = PCM_MAX;
        end
        else
        begin
            r = s[PCM_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/bmme_in_if.sv
// ----------------------------------------------------------------------------
// bmme_in_if
// Sample channel: valid/ready handshake carrying one sample word.
// ----------------------------------------------------------------------------
interface bmme_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bmme_pkg::SAMPLE_W-1:0]  sample_in;
    logic                                  last;

    modport source (output valid, output sample_in, output last, input ready);
    modport sink   (input valid, input sample_in, input last, output ready);
endinterface

### hw/rtl/bmme_out_if.sv
// ----------------------------------------------------------------------------
// bmme_out_if
// Envelope channel: valid/ready handshake carrying one min/max word.
// ----------------------------------------------------------------------------
interface bmme_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bmme_pkg::PCM_W-1:0]  block_min;
    logic signed [bmme_pkg::PCM_W-1:0]  block_max;
    logic                               final_block;

    modport source (output valid, output block_min, output block_max,
                    output final_block, input ready);
    modport sink   (input valid, input block_min, input block_max,
                    input final_block, output ready);
endinterface

### hw/rtl/bmme_cfg.sv
// ----------------------------------------------------------------------------
// bmme_cfg
// Configuration registers with decoded decimation mask and clamped length.
// ----------------------------------------------------------------------------
module bmme_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bmme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmme_pkg::CFG_W-1:0]        cfg_wdata,
    output bmme_pkg::cfg_t                    cfg
);

    logic [bmme_pkg::SHIFT_W-1:0]  shift_reg;
    logic [bmme_pkg::LENREG_W-1:0] length_reg;
    logic [bmme_pkg::LEN_W-1:0]    len_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= bmme_pkg::SHIFT_KEEP_ALL;
            length_reg <= bmme_pkg::BLOCK_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmme_pkg::REG_DECIMATE_SHIFT:
                begin
                    shift_reg <= cfg_wdata[bmme_pkg::SHIFT_W-1:0];
                end
                bmme_pkg::REG_BLOCK_LENGTH:
                begin
                    length_reg <= cfg_wdata[bmme_pkg::LENREG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign len_wide = bmme_pkg::LEN_W'(length_reg);

    always_comb
    begin
        case (shift_reg)
            bmme_pkg::SHIFT_KEEP_ALL: cfg.phase_mask = 2'b00;
            bmme_pkg::SHIFT_HALF:     cfg.phase_mask = 2'b01;
            default:                  cfg.phase_mask = 2'b11;
        endcase

        if (len_wide == '0)
        begin
            cfg.eff_len = bmme_pkg::LEN_W'(1);
        end
        else if (len_wide > bmme_pkg::LEN_W'(bmme_pkg::MAX_BLOCK))
        begin
            cfg.eff_len = bmme_pkg::LEN_W'(bmme_pkg::MAX_BLOCK);
        end
        else
        begin
            cfg.eff_len = len_wide;
        end
    end

endmodule

### hw/rtl/bmme_in_stage.sv
// ----------------------------------------------------------------------------
// bmme_in_stage
// Input register: captures one sample word per cycle unless full and held.
// ----------------------------------------------------------------------------
module bmme_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    bmme_in_if.sink           samples,
    input  logic              advance,
    output bmme_pkg::item_t   item
);

    logic                                 valid_reg;
    logic signed [bmme_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                 last_reg;
    logic                                 take;

    assign samples.ready = !valid_reg || advance;
    assign take          = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= samples.sample_in;
            last_reg   <= samples.last;
        end
    end

    assign item.valid     = valid_reg;
    assign item.sample_in = sample_reg;
    assign item.last      = last_reg;

endmodule

### hw/rtl/bmme_env.sv
// ----------------------------------------------------------------------------
// bmme_env
// Decimation, saturation and running min/max with a registered result word.
// ----------------------------------------------------------------------------
module bmme_env (
    input  logic              clk,
    input  logic              rst_n,
    input  bmme_pkg::cfg_t    cfg,
    input  bmme_pkg::item_t   item,
    output logic              advance,
    bmme_out_if.source        envelope
);

    logic [bmme_pkg::SHIFT_W-1:0]      phase_reg, phase_next;
    logic [bmme_pkg::CNT_W-1:0]        count_reg, count_next;
    logic signed [bmme_pkg::PCM_W-1:0] min_reg, min_next;
    logic signed [bmme_pkg::PCM_W-1:0] max_reg, max_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [bmme_pkg::PCM_W-1:0] out_min_reg;
    logic signed [bmme_pkg::PCM_W-1:0] out_max_reg;
    logic                              out_final_reg;

    logic                              keep;
    logic                              emit;
    logic signed [bmme_pkg::PCM_W-1:0] sat;
    logic signed [bmme_pkg::PCM_W-1:0] upd_min;
    logic signed [bmme_pkg::PCM_W-1:0] upd_max;
    logic [bmme_pkg::CNT_W-1:0]        upd_count;

    assign advance = item.valid && (!out_valid_reg || envelope.ready);

    always_comb
    begin
        keep      = (phase_reg == '0);
        sat       = bmme_pkg::saturate(item.sample_in);
        upd_min   = min_reg;
        upd_max   = max_reg;
        upd_count = count_reg;
        if (keep)
        begin
            if (sat < min_reg)
            begin
                upd_min = sat;
            end
            if (sat > max_reg)
            begin
                upd_max = sat;
            end
            upd_count = count_reg + 1'b1;
        end

        emit = (keep && (bmme_pkg::LEN_W'(upd_count) >= cfg.eff_len))
            || (item.last && (upd_count != '0));

        phase_next = item.last ? '0 : ((phase_reg + 1'b1) & cfg.phase_mask);
        if (emit || item.last)
        begin
            count_next = '0;
            min_next   = bmme_pkg::PCM_MAX;
            max_next   = bmme_pkg::PCM_MIN;
        end
        else
        begin
            count_next = upd_count;
            min_next   = upd_min;
            max_next   = upd_max;
        end

        out_valid_next = out_valid_reg && !envelope.ready;
        if (advance)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            count_reg     <= '0;
            min_reg       <= bmme_pkg::PCM_MAX;
            max_reg       <= bmme_pkg::PCM_MIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_min_reg   <= upd_min;
            out_max_reg   <= upd_max;
            out_final_reg <= item.last;
        end
    end

    assign envelope.valid       = out_valid_reg;
    assign envelope.block_min   = out_min_reg;
    assign envelope.block_max   = out_max_reg;
    assign envelope.final_block = out_final_reg;

endmodule

### hw/rtl/block_min_max_envelope.sv
// ----------------------------------------------------------------------------
// block_min_max_envelope
// Min/max envelope over blocks of decimated, saturated audio samples.
//
// samples carries one 24-bit sample word and a last flag per handshake;
// envelope carries block_min, block_max and final_block, one word per
// finished block. Both use valid/ready; a word moves when both are high.
// The cfg port writes decimate_shift (index 0) and block_length (index 1).
// A sample accepted on samples reaches the envelope port in its block word
// through the input register, then the compare/update stage with its
// result register. Throughput: one sample per cycle while envelope is not
// stalled, set by the single compare-and-update stage (running min/max/count).
// When envelope is stalled with a word pending, the update stage holds and
// the input register fills, then samples.ready drops; no word is lost.
// Reset clears both registers' valid flags, the decimation phase and the
// block count, sets the running min/max to 32767/-32768, the decimation to
// keep all and the block length to 512.
// ----------------------------------------------------------------------------
module block_min_max_envelope (
    input  logic                            clk,
    input  logic                            rst_n,
    bmme_in_if.sink                         samples,
    bmme_out_if.source                      envelope,
    input  logic                            cfg_we,
    input  logic [bmme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmme_pkg::CFG_W-1:0]      cfg_wdata
);

    bmme_pkg::cfg_t  cfg;
    bmme_pkg::item_t item;
    logic            advance;

    bmme_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bmme_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .advance (advance),
        .item    (item)
    );

    bmme_env u_env (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .item     (item),
        .advance  (advance),
        .envelope (envelope)
    );

    // a block word always holds at least one kept sample
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        envelope.valid |-> (envelope.block_min <= envelope.block_max))
        else $error("block_min above block_max");

    // back-pressure only when the input register is full
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> item.valid)
        else $error("samples stalled with empty input register");

    // a stalled result keeps the pending sample in the input register
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (envelope.valid && !envelope.ready && item.valid) |=> item.valid)
        else $error("pending sample dropped during output stall");

    // the update stage advances only with a pending sample
    a_advance_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> item.valid)
        else $error("update without a pending sample");

endmodule
